@@ src/ntc_pkg.sv @@
// Shared types and constants of the NTC temperature unit.
// Used by every module under src.
`default_nettype none
package ntc_pkg;
  localparam int ADC_BITS_DEF = 10;
  localparam int CFG_W        = 16;
  localparam int BETA_W       = 14;
  localparam int T0_W         = 16;
  localparam int LOG_W        = 21;
  localparam int LOG_STAGES   = 16;
  localparam int NUM_W        = 46;
  localparam int DEN_W        = 40;
  localparam int QUO_W        = 32;
  localparam int TLM_W        = 36;
  localparam int RECIP_W      = 37;
  localparam int RECIP_SH     = 43;
  localparam int DIV100_W     = 30;
  localparam int ZERO_C_CENTI = 27315;
  localparam int OUT_MAX      = 32767;
  localparam logic [31:0] LN2_Q32 = 32'd2977044472;
  // ceil(2^43 / 100): exact divide by 100 for products below 2^36
  localparam logic [RECIP_W-1:0] RECIP_100 = 37'd87960930223;

  localparam logic [0:0] REG_BETA = 1'b0;
  localparam logic [0:0] REG_T0   = 1'b1;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RAIL  = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  typedef struct packed {
    logic                    rail;
    logic signed [LOG_W-1:0] ln_q16;
    logic [BETA_W-1:0]       beta;
    logic [T0_W-1:0]         t0;
  } ntc_item_t;
endpackage
`default_nettype wire

@@ src/ntc_fifo.sv @@
// Short queue between the front and back parts of the NTC unit.
// Depends on ntc_pkg for the item type.
`default_nettype none
module ntc_fifo (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire ntc_pkg::ntc_item_t din,
  output ntc_pkg::ntc_item_t     dout,
  output logic                   valid
);
  ntc_pkg::ntc_item_t q;
  always_ff @(posedge clk) begin
    if (rst) valid <= 1'b0;
    else valid <= push;
    q <= din;
  end
  assign dout = q;
endmodule
`default_nettype wire

@@ src/ntc_front.sv @@
// Front part: rail check, pipelined log2 of both divider arms and ln(ratio)
// in signed Q5.16. Depends on ntc_pkg.
`default_nettype none
module ntc_front #(
  parameter int ADC_BITS = ntc_pkg::ADC_BITS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  input  wire logic [ADC_BITS-1:0]         adc_sample,
  input  wire logic [ntc_pkg::BETA_W-1:0]  beta,
  input  wire logic [ntc_pkg::T0_W-1:0]    t0,
  output logic                             out_valid,
  output ntc_pkg::ntc_item_t               out_item
);
  localparam logic [ADC_BITS-1:0] FS = {ADC_BITS{1'b1}};
  localparam int LS = ntc_pkg::LOG_STAGES;

  function automatic logic [4:0] top_bit(input logic [ADC_BITS-1:0] x);
    logic [4:0] e;
    e = 5'd0;
    for (int k = 0; k < ADC_BITS; k++)
      if (x[k]) e = 5'(k);
    return e;
  endfunction

  logic        v_l    [LS+1];
  logic        rail_l [LS+1];
  logic [4:0]  es_l   [LS+1];
  logic [4:0]  er_l   [LS+1];
  logic [30:0] ms_l   [LS+1];
  logic [30:0] mr_l   [LS+1];
  logic [15:0] fs_l   [LS+1];
  logic [15:0] fr_l   [LS+1];
  logic [ntc_pkg::BETA_W-1:0] b_l [LS+1];
  logic [ntc_pkg::T0_W-1:0]   t_l [LS+1];

  logic [ADC_BITS-1:0] rest;
  logic [4:0]  es0, er0;

  logic        v1;
  logic        rail1;
  logic signed [ntc_pkg::LOG_W:0] d1;
  logic [ntc_pkg::BETA_W-1:0] b1;
  logic [ntc_pkg::T0_W-1:0]   t1;
  logic [ntc_pkg::LOG_W-1:0]  lp, ln_;
  logic [ntc_pkg::LOG_W:0]    mag;
  logic [63:0]                prod;
  logic [ntc_pkg::LOG_W-1:0]  lnmag;

  assign rest = FS - adc_sample;
  assign es0  = top_bit(adc_sample);
  assign er0  = top_bit(rest);

  always_ff @(posedge clk) begin
    if (rst) v_l[0] <= 1'b0;
    else v_l[0] <= start;
    rail_l[0] <= (adc_sample == '0) || (adc_sample == FS);
    es_l[0]   <= es0;
    er_l[0]   <= er0;
    ms_l[0]   <= 31'((62'(adc_sample) << 30) >> es0);
    mr_l[0]   <= 31'((62'(rest) << 30) >> er0);
    fs_l[0]   <= '0;
    fr_l[0]   <= '0;
    b_l[0]    <= beta;
    t_l[0]    <= t0;
  end

  for (genvar k = 0; k < LS; k++) begin : g_log
    localparam int FB = LS - 1 - k;
    logic [61:0] sqs, sqr;
    logic [31:0] ns, nr;
    assign sqs = 62'(ms_l[k]) * 62'(ms_l[k]);
    assign sqr = 62'(mr_l[k]) * 62'(mr_l[k]);
    assign ns  = sqs[61:30];
    assign nr  = sqr[61:30];
    always_ff @(posedge clk) begin
      if (rst) v_l[k+1] <= 1'b0;
      else v_l[k+1] <= v_l[k];
      rail_l[k+1] <= rail_l[k];
      es_l[k+1]   <= es_l[k];
      er_l[k+1]   <= er_l[k];
      b_l[k+1]    <= b_l[k];
      t_l[k+1]    <= t_l[k];
      ms_l[k+1]   <= ns[31] ? ns[31:1] : ns[30:0];
      mr_l[k+1]   <= nr[31] ? nr[31:1] : nr[30:0];
      fs_l[k+1]   <= fs_l[k] | (16'(ns[31]) << FB);
      fr_l[k+1]   <= fr_l[k] | (16'(nr[31]) << FB);
    end
  end

  assign lp  = {es_l[LS], fs_l[LS]};
  assign ln_ = {er_l[LS], fr_l[LS]};

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else v1 <= v_l[LS];
    rail1 <= rail_l[LS];
    d1    <= $signed({1'b0, lp}) - $signed({1'b0, ln_});
    b1    <= b_l[LS];
    t1    <= t_l[LS];
  end

  assign mag   = d1[ntc_pkg::LOG_W] ? 22'(-d1) : 22'(d1);
  assign prod  = 64'(mag) * 64'(ntc_pkg::LN2_Q32) + 64'h8000_0000;
  assign lnmag = prod[52:32];

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else out_valid <= v1;
    out_item.rail   <= rail1;
    out_item.ln_q16 <= d1[ntc_pkg::LOG_W] ? -$signed(lnmag) : $signed(lnmag);
    out_item.beta   <= b1;
    out_item.t0     <= t1;
  end
endmodule
`default_nettype wire

@@ src/ntc_back.sv @@
// Back part: denominator, pipelined restoring divide and saturation.
// Depends on ntc_pkg.
`default_nettype none
module ntc_back (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  input  wire ntc_pkg::ntc_item_t   in_item,
  output logic                      done,
  output logic signed [15:0]        temp_centi_celsius,
  output logic [1:0]                status
);
  localparam int QW = ntc_pkg::QUO_W;
  localparam int NW = ntc_pkg::NUM_W;
  localparam int DW = ntc_pkg::DEN_W;
  localparam int LW = ntc_pkg::LOG_W;
  localparam int TW = ntc_pkg::TLM_W;
  localparam int HW = TW / 2;
  localparam int PW = HW + ntc_pkg::RECIP_W;
  localparam int SW = PW + HW + 1;
  localparam int RW = ntc_pkg::DIV100_W;
  localparam int RS = ntc_pkg::RECIP_SH;

  logic [LW-1:0] lnm;
  logic [29:0]   tprod;

  logic        v_a, rail_a, lneg_a;
  logic [TW-1:0] tlm_a;
  logic [NW-1:0] num_a;
  logic signed [DW-1:0] bden_a;

  logic        v_p, rail_p, lneg_p;
  logic [PW-1:0] ph_p, pl_p;
  logic [NW-1:0] num_p;
  logic signed [DW-1:0] bden_p;

  logic [SW-1:0] sum;

  logic        v_q, rail_q, lneg_q;
  logic [RW-1:0] q_q;
  logic [NW-1:0] num_q;
  logic signed [DW-1:0] bden_q;

  logic        v_b, rail_b, neg_b;
  logic [NW-1:0] num_b;
  logic [DW-1:0] den_b;

  logic        v_s   [QW+1];
  logic        rail_s[QW+1];
  logic        neg_s [QW+1];
  logic [NW-1:0] rem_s [QW+1];
  logic [DW-1:0] den_s [QW+1];
  logic [QW-1:0] quo_s [QW+1];

  logic signed [DW-1:0] q100, den_c;

  assign lnm   = in_item.ln_q16[LW-1] ? LW'(-in_item.ln_q16) : LW'(in_item.ln_q16);
  assign tprod = 30'(in_item.t0) * 30'(in_item.beta);

  always_ff @(posedge clk) begin
    if (rst) v_a <= 1'b0;
    else v_a <= in_valid;
    rail_a <= in_item.rail;
    lneg_a <= in_item.ln_q16[LW-1];
    tlm_a  <= TW'(in_item.t0) * TW'(lnm);
    num_a  <= NW'(tprod) << 16;
    bden_a <= $signed(DW'(in_item.beta) << 16);
  end

  always_ff @(posedge clk) begin
    if (rst) v_p <= 1'b0;
    else v_p <= v_a;
    rail_p <= rail_a;
    lneg_p <= lneg_a;
    ph_p   <= PW'(tlm_a[TW-1:HW]) * PW'(ntc_pkg::RECIP_100);
    pl_p   <= PW'(tlm_a[HW-1:0]) * PW'(ntc_pkg::RECIP_100);
    num_p  <= num_a;
    bden_p <= bden_a;
  end

  assign sum = (SW'(ph_p) << HW) + SW'(pl_p);

  always_ff @(posedge clk) begin
    if (rst) v_q <= 1'b0;
    else v_q <= v_p;
    rail_q <= rail_p;
    lneg_q <= lneg_p;
    q_q    <= sum[RS+RW-1:RS];
    num_q  <= num_p;
    bden_q <= bden_p;
  end

  assign q100  = lneg_q ? -$signed(DW'(q_q)) : $signed(DW'(q_q));
  assign den_c = q100 + bden_q;

  always_ff @(posedge clk) begin
    if (rst) v_b <= 1'b0;
    else v_b <= v_q;
    rail_b <= rail_q;
    neg_b  <= den_c <= 0;
    num_b  <= num_q;
    den_b  <= den_c;
  end

  assign v_s[0] = v_b;
  assign rail_s[0] = rail_b;
  assign neg_s[0] = neg_b;
  assign rem_s[0] = num_b;
  assign den_s[0] = den_b;
  assign quo_s[0] = '0;

  for (genvar k = 0; k < QW; k++) begin : g_div
    localparam int SH = QW - 1 - k;
    logic [NW+QW-1:0] dsh;
    logic             fit;
    assign dsh = (NW+QW)'(den_s[k]) << SH;
    assign fit = (NW+QW)'(rem_s[k]) >= dsh;
    always_ff @(posedge clk) begin
      if (rst) v_s[k+1] <= 1'b0;
      else v_s[k+1] <= v_s[k];
      rail_s[k+1] <= rail_s[k];
      neg_s[k+1]  <= neg_s[k];
      den_s[k+1]  <= den_s[k];
      rem_s[k+1]  <= fit ? NW'((NW+QW)'(rem_s[k]) - dsh) : rem_s[k];
      quo_s[k+1]  <= quo_s[k] | (QW'(fit) << SH);
    end
  end

  logic signed [QW:0] tcc;
  assign tcc = $signed({1'b0, quo_s[QW]}) - (QW+1)'(ntc_pkg::ZERO_C_CENTI);

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else done <= v_s[QW];
    priority if (rail_s[QW]) begin
      temp_centi_celsius <= '0;
      status <= ntc_pkg::ST_RAIL;
    end else if (neg_s[QW] || tcc > (QW+1)'(ntc_pkg::OUT_MAX)) begin
      temp_centi_celsius <= 16'(ntc_pkg::OUT_MAX);
      status <= ntc_pkg::ST_RANGE;
    end else begin
      temp_centi_celsius <= 16'(tcc);
      status <= ntc_pkg::ST_OK;
    end
  end
endmodule
`default_nettype wire

@@ src/ntc_thermistor_to_temperature_unit.sv @@
// Top level of the NTC thermistor beta-equation temperature unit.
// Depends on ntc_pkg, ntc_front, ntc_fifo and ntc_back.
//
// channel  | handshake          | words
// input    | start / busy       | adc_sample
// result   | done (strobe)      | temp_centi_celsius, status
// config   | cfg_we             | cfg_index, cfg_data
//
// One sample per cycle; the front holds the 16-step log2, then come the
// queue register and the back (divide by 100 and 32-stage divider).
// busy is always low: the pipeline never stalls.
// rst clears valid bits and loads beta 3700, T0 29815 centikelvin.
`default_nettype none
module ntc_thermistor_to_temperature_unit #(
  parameter int ADC_BITS = ntc_pkg::ADC_BITS_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      start,
  output logic                           busy,
  input  wire logic [ADC_BITS-1:0]       adc_sample,
  input  wire logic                      cfg_we,
  input  wire logic [0:0]                cfg_index,
  input  wire logic [ntc_pkg::CFG_W-1:0] cfg_data,
  output logic                           done,
  output logic signed [15:0]             temp_centi_celsius,
  output logic [1:0]                     status
);
  logic [ntc_pkg::BETA_W-1:0] beta;
  logic [ntc_pkg::T0_W-1:0]   t0;
  logic fv, qv;
  ntc_pkg::ntc_item_t fi, qi;

  always_ff @(posedge clk) begin
    if (rst) begin
      beta <= 14'd3700;
      t0   <= 16'd29815;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ntc_pkg::REG_BETA: beta <= cfg_data[ntc_pkg::BETA_W-1:0];
        ntc_pkg::REG_T0:   t0   <= cfg_data;
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  ntc_front #(.ADC_BITS(ADC_BITS)) u_front (
    .clk(clk), .rst(rst), .start(start), .adc_sample(adc_sample),
    .beta(beta), .t0(t0), .out_valid(fv), .out_item(fi));
  ntc_fifo u_fifo (.clk(clk), .rst(rst), .push(fv), .din(fi), .dout(qi), .valid(qv));
  ntc_back u_back (
    .clk(clk), .rst(rst), .in_valid(qv), .in_item(qi), .done(done),
    .temp_centi_celsius(temp_centi_celsius), .status(status));

  a_status: assert property (@(posedge clk) disable iff (rst)
    done |-> (status == ntc_pkg::ST_OK || status == ntc_pkg::ST_RAIL
              || status == ntc_pkg::ST_RANGE))
    else $error("bad status");
  a_rail: assert property (@(posedge clk) disable iff (rst)
    (done && status == ntc_pkg::ST_RAIL) |-> temp_centi_celsius == 16'sd0)
    else $error("rail word not zero");
  a_range: assert property (@(posedge clk) disable iff (rst)
    (done && status == ntc_pkg::ST_RANGE) |-> temp_centi_celsius == 16'sd32767)
    else $error("range word not saturated");
endmodule
`default_nettype wire
